/* design/sorted_interval_table_core_macros.svh */
// Assertion macros shared by the interval table block.
`ifndef SORTED_INTERVAL_TABLE_CORE_MACROS_SVH
`define SORTED_INTERVAL_TABLE_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/sit_pkg.sv */
// Types, constants and codes of the sorted interval table.
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_RM_IDX = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_RM_ID  = 3'd3,
    OP_MOVE   = 3'd4,
    OP_DUP    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOTF  = 2'd2,
    ST_MISS  = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_RCAP,
    S_PSCAN,
    S_MAX0,
    S_MAX,
    S_LK_FWD,
    S_LK_BWD,
    S_LK_BCHK,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic  load;
    logic  ptr_clr;
    logic  ptr_inc;
    logic  ptr_dec;
    logic  ptr_posn;
    logic  ptr_cur;
    logic  ptr_bwd;
    logic  cap;
    logic  cur_set;
    logic  take;
    logic  put;
    logic  prep_ins;
    logic  prep_new;
    logic  best_clr;
    logic  best_acc;
    logic  max_upd;
    logic  res_set;
    stat_e code;
    logic  show;
    logic  out_ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ptr_lt_cnt;
    logic       ptr_zero;
    logic       full;
    logic       pos_ok;
    logic       pre_miss;
    logic       start_le;
    logic       start_gt;
    logic       hold;
    logic       id_eq;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* design/sit_ctrl.sv */
// Controller state machine sequencing the table operations.
`timescale 1ns / 1ps
`default_nettype none
module sit_ctrl
  import sit_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t st_i,
  output ctl_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op_e'(st_i.op))
          OP_INSERT: begin
            if (st_i.full) begin
              cmd_o.res_set = 1'b1;
              cmd_o.code    = ST_FULL;
              state_d       = S_DONE;
            end else begin
              cmd_o.prep_ins = 1'b1;
              cmd_o.prep_new = 1'b1;
              cmd_o.ptr_clr  = 1'b1;
              state_d        = S_PSCAN;
            end
          end
          OP_RM_IDX: begin
            if (st_i.pos_ok) begin
              cmd_o.ptr_posn = 1'b1;
              state_d        = S_RCAP;
            end else begin
              cmd_o.res_set = 1'b1;
              cmd_o.code    = ST_NOTF;
              state_d       = S_DONE;
            end
          end
          OP_LOOKUP: begin
            if (st_i.pre_miss) begin
              cmd_o.res_set = 1'b1;
              cmd_o.code    = ST_MISS;
              state_d       = S_DONE;
            end else begin
              cmd_o.ptr_cur = 1'b1;
              state_d       = S_LK_FWD;
            end
          end
          OP_RM_ID, OP_MOVE, OP_DUP: begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_FIND;
          end
          default: begin
            cmd_o.res_set = 1'b1;
            cmd_o.code    = ST_NOTF;
            state_d       = S_DONE;
          end
        endcase
      end
      S_FIND: begin
        if (!st_i.ptr_lt_cnt) begin
          cmd_o.res_set = 1'b1;
          cmd_o.code    = ST_NOTF;
          state_d       = S_DONE;
        end else if (st_i.id_eq) begin
          if (op_e'(st_i.op) == OP_DUP) begin
            if (st_i.full) begin
              cmd_o.res_set = 1'b1;
              cmd_o.code    = ST_FULL;
              state_d       = S_DONE;
            end else begin
              cmd_o.cap      = 1'b1;
              cmd_o.prep_new = 1'b1;
              cmd_o.ptr_clr  = 1'b1;
              state_d        = S_PSCAN;
            end
          end else if (op_e'(st_i.op) == OP_MOVE) begin
            // Drop the entry and place it again at the new start
            cmd_o.cap     = 1'b1;
            cmd_o.take    = 1'b1;
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_PSCAN;
          end else begin
            cmd_o.cap  = 1'b1;
            cmd_o.take = 1'b1;
            state_d    = S_MAX0;
          end
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_RCAP: begin
        cmd_o.cap  = 1'b1;
        cmd_o.take = 1'b1;
        state_d    = S_MAX0;
      end
      S_PSCAN: begin
        if (st_i.ptr_lt_cnt && st_i.start_le) begin
          cmd_o.ptr_inc = 1'b1;
        end else begin
          cmd_o.put = 1'b1;
          state_d   = S_MAX0;
        end
      end
      S_MAX0: begin
        cmd_o.ptr_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d        = S_MAX;
      end
      S_MAX: begin
        if (st_i.ptr_lt_cnt) begin
          cmd_o.best_acc = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
        end else begin
          cmd_o.max_upd = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.show    = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_LK_FWD: begin
        if (!st_i.ptr_lt_cnt || st_i.start_gt) begin
          cmd_o.ptr_bwd = 1'b1;
          state_d       = S_LK_BWD;
        end else if (st_i.hold) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cur_set = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.show    = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_LK_BWD: begin
        if (st_i.ptr_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.code    = ST_MISS;
          state_d       = S_DONE;
        end else begin
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_LK_BCHK;
        end
      end
      S_LK_BCHK: begin
        if (st_i.hold) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cur_set = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.show    = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_LK_BWD;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/sit_datapath.sv */
// Datapath: entry registers, scan pointer, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module sit_datapath
  import sit_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctl_cmd_t    cmd_i,
  output dp_stat_t         st_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [30:0] time_value_i,
  input  wire logic [30:0] duration_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [31:0] clip_key_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       entry_index_o,
  output logic [31:0]      entry_id_o,
  output logic [30:0]      entry_start_o,
  output logic [30:0]      entry_length_o,
  output logic [31:0]      max_end_o
);

  logic [30:0] st_q [CAPACITY];
  logic [30:0] ln_q [CAPACITY];
  logic [31:0] id_q [CAPACITY];

  logic [2:0]       op_q;
  logic [30:0]      t_q, dur_q;
  logic [7:0]       posn_q;
  logic [31:0]      key_q;
  logic [CNT_W-1:0] cnt_q, ptr_q;
  logic [IDX_W-1:0] cur_q, e_idx_q;
  logic [31:0]      nid_q, maxe_q, best_q, e_id_q;
  logic [30:0]      e_start_q, e_len_q;
  stat_e            code_q;
  logic             show_q, out_valid_q;

  logic [IDX_W-1:0] ra;
  logic [30:0]      rd_st, rd_ln;
  logic [31:0]      rd_id, rd_end;
  logic [CNT_W-1:0] cnt_dec;
  logic             cur_lt_cnt;

  assign ra      = ptr_q[IDX_W-1:0];
  assign rd_st   = st_q[ra];
  assign rd_ln   = ln_q[ra];
  assign rd_id   = id_q[ra];
  assign rd_end  = {1'b0, rd_st} + {1'b0, rd_ln};
  assign cnt_dec = cnt_q - CNT_W'(1);
  assign cur_lt_cnt = (32'(cur_q) < 32'(cnt_q));

  // Status towards the controller
  always_comb begin
    st_o.op         = op_q;
    st_o.ptr_lt_cnt = (ptr_q < cnt_q);
    st_o.ptr_zero   = (ptr_q == '0);
    st_o.full       = (cnt_q == CNT_W'(CAPACITY));
    st_o.pos_ok     = (32'(posn_q) < 32'(cnt_q));
    st_o.pre_miss   = (cnt_q == '0) || (t_q < st_q[0]) || ({1'b0, t_q} >= maxe_q);
    st_o.start_le   = (rd_st <= t_q);
    st_o.start_gt   = (t_q < rd_st);
    st_o.hold       = (t_q >= rd_st) && ({1'b0, t_q} < rd_end);
    st_o.id_eq      = (rd_id == key_q);
    st_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Entry storage: parallel shift on insert and removal
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < CAPACITY; j++) begin
      if (cmd_i.put) begin
        if (j == 32'(ptr_q)) begin
          st_q[j] <= t_q;
          ln_q[j] <= e_len_q;
          id_q[j] <= e_id_q;
        end else if (j > 32'(ptr_q) && j <= 32'(cnt_q)) begin
          st_q[j] <= st_q[(j > 0) ? j - 1 : 0];
          ln_q[j] <= ln_q[(j > 0) ? j - 1 : 0];
          id_q[j] <= id_q[(j > 0) ? j - 1 : 0];
        end
      end else if (cmd_i.take) begin
        if (j >= 32'(ptr_q) && j < CAPACITY - 1) begin
          st_q[j] <= st_q[(j < CAPACITY - 1) ? j + 1 : j];
          ln_q[j] <= ln_q[(j < CAPACITY - 1) ? j + 1 : j];
          id_q[j] <= id_q[(j < CAPACITY - 1) ? j + 1 : j];
        end
      end
    end
  end

  // Latched request and captured entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      t_q    <= time_value_i;
      dur_q  <= duration_i;
      posn_q <= position_i;
      key_q  <= clip_key_i;
    end
    if (cmd_i.cap) begin
      e_idx_q   <= ra;
      e_start_q <= rd_st;
      e_len_q   <= rd_ln;
    end
    if (cmd_i.prep_ins) begin
      e_len_q <= dur_q;
    end
    if (cmd_i.prep_new) begin
      e_id_q <= nid_q;
    end else if (cmd_i.cap) begin
      e_id_q <= rd_id;
    end
    if (cmd_i.put) begin
      e_idx_q   <= ra;
      e_start_q <= t_q;
    end
    if (cmd_i.best_clr) begin
      best_q <= '0;
    end else if (cmd_i.best_acc && rd_end > best_q) begin
      best_q <= rd_end;
    end
    if (cmd_i.res_set) begin
      code_q <= cmd_i.code;
      show_q <= cmd_i.show;
    end
    if (cmd_i.out_ld) begin
      status_o       <= code_q;
      entry_index_o  <= show_q ? 8'(e_idx_q) : '0;
      entry_id_o     <= show_q ? e_id_q : '0;
      entry_start_o  <= show_q ? e_start_q : '0;
      entry_length_o <= show_q ? e_len_q : '0;
      max_end_o      <= maxe_q;
    end
  end

  // Control state: count, cursor, pointer, id counter, max end, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      ptr_q       <= '0;
      nid_q       <= 32'd1;
      maxe_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_q - CNT_W'(1);
      end else if (cmd_i.ptr_posn) begin
        ptr_q <= CNT_W'(posn_q);
      end else if (cmd_i.ptr_cur) begin
        ptr_q <= cur_lt_cnt ? CNT_W'(cur_q) : '0;
      end else if (cmd_i.ptr_bwd) begin
        ptr_q <= cur_lt_cnt ? CNT_W'(cur_q) : cnt_q;
      end
      if (cmd_i.put) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.take) begin
        cnt_q <= cnt_dec;
        // Clamp cursor into the shrunken table
        if (32'(cur_q) >= 32'(cnt_dec)) begin
          cur_q <= (cnt_dec == '0) ? '0 : IDX_W'(cnt_dec - CNT_W'(1));
        end
      end
      if (cmd_i.cur_set) begin
        cur_q <= ra;
      end
      if (cmd_i.prep_new) begin
        nid_q <= nid_q + 32'd1;
      end
      if (cmd_i.max_upd) begin
        maxe_q <= best_q;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* design/sorted_interval_table_core.sv */
// Top level of the sorted interval table: controller plus datapath.
//
//   channel | direction | handshake            | fields
//   in      | in        | in_valid_i/in_stall_o | opcode, time, duration, position, key
//   out     | out       | out_valid_o/out_stall_i | status, index, id, start, length, max end
//
// One item at a time: no new item is taken until the result of the last one
// is registered. A move runs longest (id search, insert scan and max-end pass
// at one entry a cycle; a lookup's backward walk steps and then checks each entry).
// Reset clears count, cursor and max end and sets the id counter to one.
// A result held by out_stall_i stalls the next item at its end; the next
// item is taken as soon as the result is registered.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_interval_table_core_macros.svh"
module sorted_interval_table_core
  import sit_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [30:0] time_value_i,
  input  wire logic [30:0] duration_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [31:0] clip_key_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       entry_index_o,
  output logic [31:0]      entry_id_o,
  output logic [30:0]      entry_start_o,
  output logic [30:0]      entry_length_o,
  output logic [31:0]      max_end_o
);

  ctl_cmd_t cmd;
  dp_stat_t dp_st;

  sit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (dp_st),
    .cmd_o      (cmd)
  );

  sit_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (dp_st),
    .opcode_i       (opcode_i),
    .time_value_i   (time_value_i),
    .duration_i     (duration_i),
    .position_i     (position_i),
    .clip_key_i     (clip_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .entry_index_o  (entry_index_o),
    .entry_id_o     (entry_id_o),
    .entry_start_o  (entry_start_o),
    .entry_length_o (entry_length_o),
    .max_end_o      (max_end_o)
  );

  // Block is busy in the cycle after a transfer in
  `SIT_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o, "not busy after transfer")

  // Failed operations carry no entry
  `SIT_ASSERT_NOW(a_fail_clears, out_valid_o && status_o != ST_OK, entry_id_o == 32'd0 && entry_index_o == 8'd0, "failed result carries entry")

  // An insert never writes into a full table
  `SIT_ASSERT_NOW(a_put_room, cmd.put, !dp_st.full, "insert into full table")

endmodule
`default_nettype wire

/* tb/sv/tb_sorted_interval_table_core.sv */
// Self-checking testbench for the sorted interval table core.
`timescale 1ns / 1ps

module tb_sorted_interval_table_core;
  import sit_pkg::*;

  // Opcodes the block does not define; it must answer them with not-found
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 500;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  idx;
    logic [31:0] id;
    logic [30:0] start;
    logic [30:0] length;
    logic [31:0] max_end;
  } table_result_t;

  // Interval table predictor plus queue of expected responses
  class interval_table_scoreboard;
    logic [30:0]   starts [CAPACITY];
    logic [30:0]   lengths[CAPACITY];
    logic [31:0]   ids    [CAPACITY];
    int            count;
    int            cursor;
    logic [31:0]   next_key;
    logic [31:0]   max_end;
    table_result_t awaited[$];
    int            mismatches;

    function new();
      count = 0;
      cursor = 0;
      next_key = 32'd1;
      max_end = 32'd0;
      mismatches = 0;
    endfunction

    function logic [31:0] end_of(int k);
      return {1'b0, starts[k]} + {1'b0, lengths[k]};
    endfunction

    function void refresh_max();
      logic [31:0] best;
      best = 32'd0;
      for (int k = 0; k < count; k++) if (end_of(k) > best) best = end_of(k);
      max_end = best;
    endfunction

    // Insert after every entry with an equal or smaller start
    function int place(logic [30:0] s, logic [30:0] len, logic [31:0] key);
      int pos;
      pos = 0;
      while (pos < count && starts[pos] <= s) pos++;
      for (int k = count; k > pos; k--) begin
        starts[k] = starts[k-1];
        lengths[k] = lengths[k-1];
        ids[k] = ids[k-1];
      end
      starts[pos] = s;
      lengths[pos] = len;
      ids[pos] = key;
      count++;
      refresh_max();
      return pos;
    endfunction

    // Close the gap and clamp the cursor
    function void take_out(int pos);
      for (int k = pos; k + 1 < count; k++) begin
        starts[k] = starts[k+1];
        lengths[k] = lengths[k+1];
        ids[k] = ids[k+1];
      end
      count--;
      if (cursor >= count) cursor = (count == 0) ? 0 : count - 1;
      refresh_max();
    endfunction

    function bit find_key(logic [31:0] key, output int pos);
      pos = 0;
      for (int k = 0; k < count; k++) begin
        if (ids[k] == key) begin
          pos = k;
          return 1;
        end
      end
      return 0;
    endfunction

    function bit holds(int k, logic [30:0] t);
      return t >= starts[k] && {1'b0, t} < end_of(k);
    endfunction

    // Cursor entry, its neighbour, forward scan, then backward scan
    function bit search(logic [30:0] t, output int pos);
      int i;
      int k;
      pos = 0;
      if (count == 0) return 0;
      if (t < starts[0] || {1'b0, t} >= max_end) return 0;
      i = (cursor >= count) ? 0 : cursor;
      if (holds(i, t)) begin
        pos = i;
        return 1;
      end
      if (i + 1 < count && holds(i + 1, t)) begin
        cursor = i + 1;
        pos = i + 1;
        return 1;
      end
      for (k = i; k < count; k++) begin
        if (t < starts[k]) break;
        if (holds(k, t)) begin
          cursor = k;
          pos = k;
          return 1;
        end
      end
      k = (cursor < count) ? cursor : count;
      while (k > 0) begin
        k--;
        if (holds(k, t)) begin
          cursor = k;
          pos = k;
          return 1;
        end
      end
      return 0;
    endfunction

    // Apply one accepted command and queue the response it must produce
    function void note_command(logic [2:0] op, logic [30:0] t, logic [30:0] dur,
                               logic [7:0] posn, logic [31:0] key);
      table_result_t r;
      int pos;
      bit ok;
      r = '{status: ST_NOTF, idx: '0, id: '0, start: '0, length: '0, max_end: '0};
      case (op)
        OP_INSERT: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            r.id = next_key;
            next_key++;
            r.idx = 8'(place(t, dur, r.id));
            r.start = t;
            r.length = dur;
            r.status = ST_OK;
          end
        end
        OP_RM_IDX, OP_RM_ID: begin
          if (op == OP_RM_IDX) begin
            pos = posn;
            ok = pos < count;
          end else begin
            ok = find_key(key, pos);
          end
          if (ok) begin
            r.idx = 8'(pos);
            r.id = ids[pos];
            r.start = starts[pos];
            r.length = lengths[pos];
            take_out(pos);
            r.status = ST_OK;
          end
        end
        OP_LOOKUP: begin
          if (search(t, pos)) begin
            r.idx = 8'(pos);
            r.id = ids[pos];
            r.start = starts[pos];
            r.length = lengths[pos];
            r.status = ST_OK;
          end else begin
            r.status = ST_MISS;
          end
        end
        OP_MOVE: begin
          if (find_key(key, pos)) begin
            r.id = ids[pos];
            r.length = lengths[pos];
            take_out(pos);
            r.idx = 8'(place(t, r.length, r.id));
            r.start = t;
            r.status = ST_OK;
          end
        end
        OP_DUP: begin
          if (find_key(key, pos)) begin
            if (count >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              r.length = lengths[pos];
              r.id = next_key;
              next_key++;
              r.idx = 8'(place(t, r.length, r.id));
              r.start = t;
              r.status = ST_OK;
            end
          end
        end
        default: ;
      endcase
      r.max_end = max_end;
      awaited.push_back(r);
    endfunction

    // Compare one response with the oldest expectation
    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: response with nothing awaited");
        return;
      end
      exp_r = awaited.pop_front();
      if (got.status !== exp_r.status || got.idx !== exp_r.idx || got.id !== exp_r.id ||
          got.start !== exp_r.start || got.length !== exp_r.length ||
          got.max_end !== exp_r.max_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp st=%0d ix=%0d id=%0h s=%0d l=%0d me=%0d",
                    " / got st=%0d ix=%0d id=%0h s=%0d l=%0d me=%0d"},
                   exp_r.status, exp_r.idx, exp_r.id, exp_r.start, exp_r.length,
                   exp_r.max_end, got.status, got.idx, got.id, got.start, got.length,
                   got.max_end);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = 3'd0;
  logic [30:0] time_value_i = '0;
  logic [30:0] duration_i = '0;
  logic [7:0]  position_i = '0;
  logic [31:0] clip_key_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  entry_index_o;
  logic [31:0] entry_id_o;
  logic [30:0] entry_start_o;
  logic [30:0] entry_length_o;
  logic [31:0] max_end_o;

  interval_table_scoreboard tracker = new();
  int  commands_sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  table_result_t seen;

  sorted_interval_table_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send_command(logic [2:0] op, logic [30:0] t, logic [30:0] dur,
                              logic [7:0] posn, logic [31:0] key);
    int gap;
    gap = ((commands_sent / 250) % 4 == 1) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    time_value_i <= t;
    duration_i <= dur;
    position_i <= posn;
    clip_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_command(op, t, dur, posn, key);
    commands_sent++;
  endtask

  // Sink side: check each transfer, stall at random, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.status = status_o;
        seen.idx = entry_index_o;
        seen.id = entry_id_o;
        seen.start = entry_start_o;
        seen.length = entry_length_o;
        seen.max_end = max_end_o;
        tracker.check_result(seen);
      end
      if (!hold_done && commands_sent >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if ((commands_sent / 250) % 4 != 2 && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int r;
    logic [2:0]  op;
    logic [30:0] t;
    logic [30:0] dur;
    logic [7:0]  posn;
    logic [31:0] key;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unknown ids, spare opcodes
    send_command(OP_LOOKUP, 31'd5, 31'd0, 8'd0, 32'd0);
    send_command(OP_RM_IDX, 31'd0, 31'd0, 8'd0, 32'd0);
    send_command(OP_RM_ID, 31'd0, 31'd0, 8'd0, 32'd5);
    send_command(OP_MOVE, 31'd7, 31'd0, 8'd0, 32'd1);
    send_command(OP_DUP, 31'd7, 31'd0, 8'd0, 32'hFFFF_FFFF);
    send_command(OP_SPARE6, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_command(OP_SPARE7, 31'd0, 31'd0, 8'd0, 32'd0);
    // Widest interval, a zero-length one, equal starts
    send_command(OP_INSERT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd0, 32'd0);
    send_command(OP_INSERT, 31'd0, 31'd0, 8'd0, 32'd0);
    send_command(OP_INSERT, 31'd100, 31'd50, 8'd0, 32'd0);
    send_command(OP_INSERT, 31'd100, 31'd10, 8'd0, 32'd0);
    send_command(OP_LOOKUP, 31'd0, 31'd0, 8'd0, 32'd0);
    send_command(OP_LOOKUP, 31'd105, 31'd0, 8'd0, 32'd0);
    send_command(OP_LOOKUP, 31'd120, 31'd0, 8'd0, 32'd0);
    send_command(OP_LOOKUP, 31'd99, 31'd0, 8'd0, 32'd0);
    send_command(OP_LOOKUP, 31'h7FFF_FFFF, 31'd0, 8'd0, 32'd0);
    send_command(OP_DUP, 31'd500, 31'd0, 8'd0, 32'd3);
    send_command(OP_MOVE, 31'd50, 31'd0, 8'd0, 32'd4);
    send_command(OP_LOOKUP, 31'd55, 31'd0, 8'd0, 32'd0);
    // Fill up, then full insert and full duplicate
    while (tracker.count < CAPACITY)
      send_command(OP_INSERT, 31'($urandom_range(0, 1000)), 31'($urandom_range(1, 200)),
                   8'd0, 32'd0);
    send_command(OP_INSERT, 31'd10, 31'd10, 8'd0, 32'd0);
    send_command(OP_DUP, 31'd10, 31'd0, 8'd0, 32'd3);
    send_command(OP_RM_IDX, 31'd0, 31'd0, 8'd255, 32'd0);
    send_command(OP_LOOKUP, 31'h7FFF_FFFE, 31'd0, 8'd0, 32'd0);
    send_command(OP_RM_IDX, 31'd0, 31'd0, 8'(CAPACITY - 1), 32'd0);
    while (tracker.count > 0) send_command(OP_RM_IDX, 31'd0, 31'd0, 8'd0, 32'd0);

    // Random: mostly meaningful keys, positions and overlapping times
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (tracker.count > 12 && r < 30) r = r + 40;
      if (r < 30) op = OP_INSERT;
      else if (r < 62) op = OP_LOOKUP;
      else if (r < 70) op = OP_RM_IDX;
      else if (r < 78) op = OP_RM_ID;
      else if (r < 88) op = OP_MOVE;
      else if (r < 97) op = OP_DUP;
      else op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      t = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 2000));
      dur = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 300));
      posn = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
             8'($urandom_range(0, tracker.count + 1));
      key = ($urandom_range(0, 7) == 0) ? 32'($urandom) :
            tracker.next_key - 32'($urandom_range(1, 24));
      send_command(op, t, dur, posn, key);
    end
    in_valid_i <= 1'b0;

    // Drain, then allow the block's latency to pass
    while (tracker.awaited.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/sit_pkg.sv
design/sit_ctrl.sv
design/sit_datapath.sv
design/sorted_interval_table_core.sv
tb/sv/tb_sorted_interval_table_core.sv
